// ===== hw/rtl/mfh_pkg.sv =====
`default_nettype none

package mfh_pkg;

    localparam int unsigned TYPE_W = 4;
    localparam int unsigned FLAGS_W = 4;
    localparam int unsigned LEN_W = 28;
    localparam int unsigned ERR_W = 2;
    localparam int unsigned GROUP_W = 7;
    localparam int unsigned SEEN_W = 2;
    localparam int unsigned OUT_TDATA_W = 40;

    localparam logic [TYPE_W-1:0] TYPE_RESERVED = 4'd0;
    localparam logic [TYPE_W-1:0] TYPE_PUBLISH = 4'd3;
    localparam logic [TYPE_W-1:0] TYPE_PUBREL = 4'd6;
    localparam logic [TYPE_W-1:0] TYPE_SUBSCRIBE = 4'd8;
    localparam logic [TYPE_W-1:0] TYPE_UNSUBSCRIBE = 4'd10;

    localparam logic [FLAGS_W-1:0] FLAGS_FIXED_ONE = 4'h2;
    localparam logic [FLAGS_W-1:0] FLAGS_NONE = 4'h0;

    localparam logic [SEEN_W-1:0] SEEN_LAST = 2'd3;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK = 2'd0,
        ERR_RESERVED_TYPE = 2'd1,
        ERR_BAD_FLAGS = 2'd2,
        ERR_LENGTH_LONG = 2'd3
    } err_t;

    typedef enum logic {
        PHASE_FIRST = 1'b0,
        PHASE_LENGTH = 1'b1
    } phase_t;

    typedef struct packed {
        phase_t              phase;
        logic [TYPE_W-1:0]   held_type;
        logic [FLAGS_W-1:0]  held_flags;
        logic [LEN_W-1:0]    length_sum;
        logic [SEEN_W-1:0]   length_bytes_seen;
    } state_t;

    typedef struct packed {
        logic [TYPE_W-1:0]   packet_type;
        logic [FLAGS_W-1:0]  header_flags;
        logic [LEN_W-1:0]    decoded_length;
        err_t                error_code;
    } result_t;

    function automatic logic flags_ok(input logic [TYPE_W-1:0] typ,
                                      input logic [FLAGS_W-1:0] flg);
        logic ok;
        if (typ == TYPE_PUBLISH)
        begin
            ok = 1'b1;
        end
        else if (typ == TYPE_PUBREL || typ == TYPE_SUBSCRIBE || typ == TYPE_UNSUBSCRIBE)
        begin
            ok = (flg == FLAGS_FIXED_ONE);
        end
        else
        begin
            ok = (flg == FLAGS_NONE);
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mqtt_fixed_header_parser.sv =====
// result path: the byte that completes a result is held in the input register, then its result is registered
// throughput: one header byte per cycle, set by the single decode stage between
// the input register and the result register; the input side stalls only while
// the result register holds an untaken result
// reset: rst_n is asynchronous, active low; clears both valid flags and the parse state
`default_nettype none

module mqtt_fixed_header_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic  [7:0] s_axis_tdata,   // data_byte[7:0]
    input  wire logic        s_axis_tuser,   // restart
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // packet_type[3:0], header_flags[7:4], decoded_length[35:8],
    // error_code[37:36], zero[39:38]
    output logic [mfh_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import mfh_pkg::*;

    logic        in_vld_reg;
    logic [7:0]  in_byte_reg;
    logic        in_restart_reg;
    logic        advance;

    state_t      state_reg;
    state_t      state_next;
    logic        step_valid;
    result_t     step_result;

    logic        out_vld_reg;
    logic        out_vld_next;
    result_t     out_res_reg;

    assign advance = in_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !in_vld_reg || advance;

    mfh_step u_step (
        .data_byte    (in_byte_reg),
        .restart      (in_restart_reg),
        .state        (state_reg),
        .state_next   (state_next),
        .result_valid (step_valid),
        .result       (step_result)
    );

    always_comb
    begin
        out_vld_next = out_vld_reg && !m_axis_tready;
        if (advance)
        begin
            out_vld_next = step_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg <= '{phase: PHASE_FIRST, held_type: '0, held_flags: '0,
                           length_sum: '0, length_bytes_seen: '0};
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_vld_reg <= s_axis_tvalid;
            end
            out_vld_reg <= out_vld_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_restart_reg <= s_axis_tuser;
        end
        if (advance && step_valid)
        begin
            out_res_reg <= step_result;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata = {2'b00, out_res_reg.error_code, out_res_reg.decoded_length,
                           out_res_reg.header_flags, out_res_reg.packet_type};

`ifndef SYNTHESIS
    // error results never carry a type or a length
    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_res_reg.error_code != ERR_OK) |->
        (out_res_reg.packet_type == TYPE_RESERVED && out_res_reg.decoded_length == '0))
        else $error("error result with nonzero type or length");

    // waiting for a first byte means no length in progress
    a_first_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PHASE_FIRST) |->
        (state_reg.length_sum == '0 && state_reg.length_bytes_seen == '0))
        else $error("length state left over in first-byte phase");

    // a held byte that cannot advance stays held
    a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !advance) |=> (in_vld_reg && $stable(in_byte_reg)))
        else $error("stalled input byte lost");

    // the state moves only with a byte through the decode stage
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("parse state changed without a byte");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/mfh_step.sv =====
`default_nettype none

module mfh_step (
    input  wire logic            [7:0] data_byte,
    input  wire logic                  restart,
    input  wire mfh_pkg::state_t       state,
    output mfh_pkg::state_t            state_next,
    output logic                       result_valid,
    output mfh_pkg::result_t           result
);
    import mfh_pkg::*;

    logic                first_byte;
    logic [TYPE_W-1:0]   byte_type;
    logic [FLAGS_W-1:0]  byte_flags;
    logic                type_bad;
    logic                flags_bad;
    logic [GROUP_W-1:0]  group;
    logic [LEN_W-1:0]    group_shifted;
    logic [LEN_W-1:0]    merged_sum;

    assign first_byte = restart || (state.phase == PHASE_FIRST);
    assign byte_type = data_byte[7:4];
    assign byte_flags = data_byte[3:0];
    assign type_bad = (byte_type == TYPE_RESERVED);
    assign flags_bad = !flags_ok(byte_type, byte_flags);
    assign group = data_byte[GROUP_W-1:0];

    always_comb
    begin
        unique case (state.length_bytes_seen)
            2'd0: group_shifted = {{(LEN_W-GROUP_W){1'b0}}, group};
            2'd1: group_shifted = {{(LEN_W-2*GROUP_W){1'b0}}, group, {GROUP_W{1'b0}}};
            2'd2: group_shifted = {{(LEN_W-3*GROUP_W){1'b0}}, group, {(2*GROUP_W){1'b0}}};
            default: group_shifted = {group, {(3*GROUP_W){1'b0}}};
        endcase
    end

    assign merged_sum = state.length_sum | group_shifted;

    // next state
    always_comb
    begin
        state_next = state;
        if (first_byte)
        begin
            state_next.phase = PHASE_FIRST;
            state_next.length_sum = '0;
            state_next.length_bytes_seen = '0;
            if (!type_bad && !flags_bad)
            begin
                state_next.held_type = byte_type;
                state_next.held_flags = byte_flags;
                state_next.phase = PHASE_LENGTH;
            end
        end
        else if (!data_byte[7] || state.length_bytes_seen == SEEN_LAST)
        begin
            state_next.phase = PHASE_FIRST;
            state_next.length_sum = '0;
            state_next.length_bytes_seen = '0;
        end
        else
        begin
            state_next.length_sum = merged_sum;
            state_next.length_bytes_seen = state.length_bytes_seen + 2'd1;
        end
    end

    // result
    always_comb
    begin
        result_valid = 1'b0;
        result.packet_type = TYPE_RESERVED;
        result.header_flags = state.held_flags;
        result.decoded_length = '0;
        result.error_code = ERR_OK;
        if (first_byte)
        begin
            result_valid = type_bad || flags_bad;
            result.header_flags = byte_flags;
            result.error_code = type_bad ? ERR_RESERVED_TYPE : ERR_BAD_FLAGS;
        end
        else if (!data_byte[7])
        begin
            result_valid = 1'b1;
            result.packet_type = state.held_type;
            result.decoded_length = merged_sum;
        end
        else if (state.length_bytes_seen == SEEN_LAST)
        begin
            result_valid = 1'b1;
            result.error_code = ERR_LENGTH_LONG;
        end
    end

endmodule

`default_nettype wire
